// ===== rtl/bmp_rle_stream_decoder_macros.svh =====
// ---------------------------------------------------------------------------
// bmp_rle_stream_decoder_macros.svh
// assertion macros used by the decoder checker
// ---------------------------------------------------------------------------
`ifndef BMP_RLE_STREAM_DECODER_MACROS_SVH
`define BMP_RLE_STREAM_DECODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BMPRLE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BMPRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bmprle_pkg.sv =====
// ---------------------------------------------------------------------------
// bmprle_pkg
// types, constants and step helpers for the BMP RLE8/RLE4 stream decoder
// ---------------------------------------------------------------------------
`default_nettype none

package bmprle_pkg;

  localparam int DataWidth  = 64;
  localparam int ColWidth   = 17;
  localparam int RowWidth   = 16;

  localparam logic [16:0] ColMax      = 17'h1FFFF;
  localparam logic [3:0]  NibbleMask  = 4'd15;
  localparam logic [7:0]  EscEol      = 8'd0;
  localparam logic [7:0]  EscEop      = 8'd1;
  localparam logic [7:0]  EscDelta    = 8'd2;

  localparam logic [1:0]  REG_DECODE_MODE  = 2'd0;
  localparam logic [1:0]  REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0]  REG_IMAGE_HEIGHT = 2'd2;

  localparam logic        ResetMode   = 1'b0;
  localparam logic [15:0] ResetWidth  = 16'd640;
  localparam logic [15:0] ResetHeight = 16'd480;

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_VALUE = 3'd1,
    PH_DX    = 3'd2,
    PH_DY    = 3'd3,
    PH_ABS   = 3'd4,
    PH_PAD   = 3'd5
  } phase_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] width;
    logic [15:0] height;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held_count;
    logic [16:0] column_pos;
    logic [15:0] row_pos;
    logic [7:0]  absolute_left;
    logic        pad_pending;
    logic        finished;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] row;
    logic [16:0] column;
    logic [7:0]  run_length;
    logic [7:0]  first_value;
    logic [7:0]  second_value;
    logic        line_end;
    logic        picture_end;
  } result_t;

  function automatic state_t start_picture(input logic [15:0] height);
    state_t s;
    s.phase         = PH_COUNT;
    s.held_count    = 8'd0;
    s.column_pos    = 17'd0;
    s.absolute_left = 8'd0;
    s.pad_pending   = 1'b0;
    s.row_pos       = (height == 16'd0) ? 16'd0 : height - 16'd1;
    s.finished      = (height == 16'd0);
    return s;
  endfunction

  function automatic logic [16:0] advance_col(input logic [16:0] col, input logic [7:0] n);
    logic [17:0] sum;
    sum = {1'b0, col} + {10'd0, n};
    return sum[17] ? ColMax : sum[16:0];
  endfunction

  function automatic logic past_width(input logic [16:0] col, input logic [15:0] width);
    return col > ({1'b0, width} + 17'd1);
  endfunction

  function automatic state_t close_line(input state_t s);
    state_t r;
    r = s;
    r.column_pos = 17'd0;
    if (s.row_pos == 16'd0) begin
      r.finished = 1'b1;
    end else begin
      r.row_pos = s.row_pos - 16'd1;
    end
    return r;
  endfunction

  function automatic result_t make_result(
    input logic [15:0] row,
    input logic [16:0] col,
    input logic [7:0]  len,
    input logic [7:0]  a,
    input logic [7:0]  b,
    input logic        le,
    input logic        pe
  );
    result_t r;
    r.valid        = 1'b1;
    r.row          = row;
    r.column       = col;
    r.run_length   = len;
    r.first_value  = a;
    r.second_value = (len == 8'd1) ? a : b;
    r.line_end     = le;
    r.picture_end  = pe;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bmprle_core.sv =====
// ---------------------------------------------------------------------------
// bmprle_core
// decoder state registers and the per-byte step logic
// ---------------------------------------------------------------------------
`default_nettype none

module bmprle_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  wire  [7:0]           data_byte,
  input  wire                  restart,
  input  wire                  cfg_restart,
  input  bmprle_pkg::cfg_t     cfg,
  output bmprle_pkg::result_t  res
);

  bmprle_pkg::state_t cur;
  bmprle_pkg::state_t st;
  bmprle_pkg::state_t nx;
  logic               pending;
  logic [7:0]         hi;
  logic [7:0]         lo;
  logic [7:0]         abs_n;
  logic [8:0]         pad_sum;
  logic               pad_calc;
  logic [15:0]        dy_row;
  logic               le;

  always_comb begin
    st  = (restart || pending) ? bmprle_pkg::start_picture(cfg.height) : cur;
    nx  = st;
    res = '0;
    le  = 1'b0;
    hi  = cfg.mode ? {4'd0, data_byte[7:4]} : data_byte;
    lo  = cfg.mode ? {4'd0, data_byte[3:0] & bmprle_pkg::NibbleMask} : data_byte;
    pad_sum  = {1'b0, data_byte} + 9'd1;
    pad_calc = cfg.mode ? pad_sum[1] : data_byte[0];
    if (cfg.mode) begin
      abs_n = (st.absolute_left >= 8'd2) ? 8'd2 : st.absolute_left;
    end else begin
      abs_n = (st.absolute_left >= 8'd1) ? 8'd1 : st.absolute_left;
    end
    dy_row = st.row_pos - {8'd0, data_byte};

    if (!st.finished) begin
      unique case (st.phase)
        bmprle_pkg::PH_VALUE: begin
          nx.phase = bmprle_pkg::PH_COUNT;
          priority if (st.held_count != 8'd0) begin
            nx.column_pos = bmprle_pkg::advance_col(st.column_pos, st.held_count);
            le = bmprle_pkg::past_width(nx.column_pos, cfg.width);
            if (le) begin
              nx = bmprle_pkg::close_line(nx);
            end
            res = bmprle_pkg::make_result(st.row_pos, st.column_pos, st.held_count,
                                          hi, lo, le, nx.finished);
          end else if (data_byte == bmprle_pkg::EscEol) begin
            nx  = bmprle_pkg::close_line(nx);
            res = bmprle_pkg::make_result(st.row_pos, st.column_pos, 8'd0, 8'd0, 8'd0,
                                          1'b1, nx.finished);
          end else if (data_byte == bmprle_pkg::EscEop) begin
            nx.finished = 1'b1;
            res = bmprle_pkg::make_result(st.row_pos, st.column_pos, 8'd0, 8'd0, 8'd0,
                                          1'b0, 1'b1);
          end else if (data_byte == bmprle_pkg::EscDelta) begin
            nx.phase = bmprle_pkg::PH_DX;
          end else begin
            nx.absolute_left = data_byte;
            nx.pad_pending   = pad_calc;
            nx.phase         = bmprle_pkg::PH_ABS;
          end
        end
        bmprle_pkg::PH_DX: begin
          nx.column_pos = bmprle_pkg::advance_col(st.column_pos, data_byte);
          nx.phase      = bmprle_pkg::PH_DY;
        end
        bmprle_pkg::PH_DY: begin
          nx.phase = bmprle_pkg::PH_COUNT;
          if ({8'd0, data_byte} > st.row_pos) begin
            nx.finished = 1'b1;
            res = bmprle_pkg::make_result(16'd0, st.column_pos, 8'd0, 8'd0, 8'd0,
                                          1'b0, 1'b1);
          end else begin
            nx.row_pos = dy_row;
            if (bmprle_pkg::past_width(st.column_pos, cfg.width)) begin
              nx  = bmprle_pkg::close_line(nx);
              res = bmprle_pkg::make_result(dy_row, st.column_pos, 8'd0, 8'd0, 8'd0,
                                            1'b1, nx.finished);
            end
          end
        end
        bmprle_pkg::PH_ABS: begin
          nx.column_pos    = bmprle_pkg::advance_col(st.column_pos, abs_n);
          nx.absolute_left = st.absolute_left - abs_n;
          if (nx.absolute_left == 8'd0) begin
            if (st.pad_pending) begin
              nx.phase = bmprle_pkg::PH_PAD;
            end else begin
              nx.phase = bmprle_pkg::PH_COUNT;
              le = bmprle_pkg::past_width(nx.column_pos, cfg.width);
              if (le) begin
                nx = bmprle_pkg::close_line(nx);
              end
            end
          end
          res = bmprle_pkg::make_result(st.row_pos, st.column_pos, abs_n, hi, lo,
                                        le, nx.finished);
        end
        bmprle_pkg::PH_PAD: begin
          nx.pad_pending = 1'b0;
          nx.phase       = bmprle_pkg::PH_COUNT;
          if (bmprle_pkg::past_width(st.column_pos, cfg.width)) begin
            nx  = bmprle_pkg::close_line(nx);
            res = bmprle_pkg::make_result(st.row_pos, st.column_pos, 8'd0, 8'd0, 8'd0,
                                          1'b1, nx.finished);
          end
        end
        default: begin
          nx.held_count = data_byte;
          nx.phase      = bmprle_pkg::PH_VALUE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= bmprle_pkg::start_picture(bmprle_pkg::ResetHeight);
      pending <= 1'b1;
    end else begin
      if (step) begin
        cur <= nx;
      end
      if (cfg_restart) begin
        pending <= 1'b1;
      end else if (step) begin
        pending <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bmp_rle_stream_decoder.sv =====
// output: a result is registered and appears on m_tvalid in the cycle after its input transaction
// throughput: one compressed byte per cycle; input stalls while a result waits on m_tready
// the per-byte step is one pass of logic between the state and output registers
// reset: RLE8, 640 x 480, decoder at picture start, output empty
// a configuration write restarts the picture at the next input byte
// ---------------------------------------------------------------------------
// bmp_rle_stream_decoder
// BMP RLE8/RLE4 stream decoder, one byte in, at most one pixel run out
// ---------------------------------------------------------------------------
`default_nettype none

module bmp_rle_stream_decoder (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // data_byte
  input  wire  [0:0]  s_tuser,   // restart
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata,   // row, column, run_length, first_value, second_value
  output logic [0:0]  m_tuser,   // line_end
  output logic        m_tlast,   // picture_end
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  bmprle_pkg::cfg_t    cfg;
  bmprle_pkg::result_t res;
  bmprle_pkg::result_t out_res;
  logic                accept;
  logic                cfg_hit;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     ((cfg_index == bmprle_pkg::REG_DECODE_MODE) ||
                      (cfg_index == bmprle_pkg::REG_IMAGE_WIDTH) ||
                      (cfg_index == bmprle_pkg::REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= bmprle_pkg::ResetMode;
      cfg.width  <= bmprle_pkg::ResetWidth;
      cfg.height <= bmprle_pkg::ResetHeight;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bmprle_pkg::REG_DECODE_MODE:  cfg.mode   <= cfg_data[0];
        bmprle_pkg::REG_IMAGE_WIDTH:  cfg.width  <= cfg_data;
        bmprle_pkg::REG_IMAGE_HEIGHT: cfg.height <= cfg_data;
        default: ;
      endcase
    end
  end

  bmprle_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .data_byte   (s_tdata),
    .restart     (s_tuser[0]),
    .cfg_restart (cfg_hit),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.second_value, out_res.first_value, out_res.run_length,
                    out_res.column, out_res.row};
  assign m_tuser = out_res.line_end;
  assign m_tlast = out_res.picture_end;

endmodule

`default_nettype wire

// ===== rtl/bmprle_checker.sv =====
// ---------------------------------------------------------------------------
// bmprle_checker
// port-level assertions for the decoder, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "bmp_rle_stream_decoder_macros.svh"

module bmprle_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [63:0] m_tdata,
  input wire [0:0]  m_tuser,
  input wire        m_tlast
);

  // stalled result transaction holds its payload
  `BMPRLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")

  // an empty output register never blocks the input
  `BMPRLE_ASSERT_IMPL(a_in_ready, !m_tvalid, s_tready, "input stalled with empty output")

  // picture end without line close is a pure marker
  `BMPRLE_ASSERT_IMPL(a_pe_marker, m_tvalid && m_tlast && !m_tuser[0], m_tdata[40:33] == 8'd0, "picture end marker carries pixels")

  // row never wraps below zero to all ones
  `BMPRLE_ASSERT_IMPL(a_row_range, m_tvalid, m_tdata[15:0] != 16'hFFFF, "row out of range")

endmodule

bind bmp_rle_stream_decoder bmprle_checker u_bmprle_checker (.*);

`default_nettype wire
